FILE: hw/rtl/etmb_pkg.sv
// Package for the Euler rotation, scale and translation matrix builder.
package etmb_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int AtanEntries = 24;
  localparam int TrigW = 28;
  localparam logic signed [TrigW-1:0] GainQ24 = 28'sd10188014;
  localparam logic signed [TrigW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [TrigW-1:0] PiQ24 = 28'sd52707179;

  typedef logic signed [TrigW-1:0] trig_t;

  // One CORDIC cell state: x, y, residual angle, quadrant flip.
  typedef struct packed {
    trig_t x;
    trig_t y;
    trig_t z;
    logic  flip;
  } rot_t;

  function automatic trig_t atan_q24(input logic [4:0] i);
    trig_t r;
    r = '0;
    unique case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      5'd8: r = 28'sd65536;
      5'd9: r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q24 times Q24, rounded half up to Q24.
  function automatic trig_t mul24(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    p = a * b + (56'sd1 <<< 23);
    return trig_t'(p >>> 24);
  endfunction

  // Q24 term times Q8.8 scale, rounded half up to Q16.16.
  function automatic logic [31:0] scaled(input trig_t t, input logic signed [15:0] k);
    logic signed [TrigW+15:0] p;
    p = t * k + 44'sd32768;
    return 32'(p >>> 16);
  endfunction

endpackage

FILE: hw/rtl/euler_trs_matrix_builder_top.sv
// Top level of the Euler rotation, scale and translation matrix builder.
// Takes one object per cycle unless stalled and gives one matrix result per object.
// The pipe has one reduction stage, one cell per CORDIC iteration, and four
// stages of products and scaling. The whole pipe advances
// whenever its last stage is empty or is being taken, so it moves one request
// per cycle while results are taken.
module euler_trs_matrix_builder_top #(
  parameter int CORDIC_STEPS = etmb_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic stall_in,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [15:0] scale_x,
  input  logic signed [15:0] scale_y,
  input  logic signed [15:0] scale_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic valid_out,
  input  logic stall_out,
  output logic signed [31:0] r0c0,
  output logic signed [31:0] r0c1,
  output logic signed [31:0] r0c2,
  output logic signed [31:0] r1c0,
  output logic signed [31:0] r1c1,
  output logic signed [31:0] r1c2,
  output logic signed [31:0] r2c0,
  output logic signed [31:0] r2c1,
  output logic signed [31:0] r2c2,
  output logic signed [31:0] trans_x,
  output logic signed [31:0] trans_y,
  output logic signed [31:0] trans_z
);
  import etmb_pkg::*;

  localparam int Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam int Depth = Steps + 5;

  typedef struct packed {
    logic [15:0] kx, ky, kz;
    logic [31:0] px, py, pz;
  } side_t;

  logic en;
  logic [Depth-1:0] vld;
  side_t side [Depth];
  rot_t chain [Steps+1][3];
  logic signed [15:0] ang [3];

  assign en = !(vld[Depth-1] && stall_out);
  assign stall_in = !en;
  assign valid_out = vld[Depth-1];
  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{kx: scale_x, ky: scale_y, kz: scale_z, px: pos_x, py: pos_y, pz: pos_z};
      for (int i = 1; i < Depth; i++) side[i] <= side[i-1];
    end
  end

  // Angle reduction into the CORDIC range.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        trig_t z;
        z = trig_t'(ang[a]) <<< 11;
        chain[0][a].x <= GainQ24;
        chain[0][a].y <= '0;
        if (z > HalfPiQ24) begin
          chain[0][a].z <= z - PiQ24;
          chain[0][a].flip <= 1'b1;
        end else if (z < -HalfPiQ24) begin
          chain[0][a].z <= z + PiQ24;
          chain[0][a].flip <= 1'b1;
        end else begin
          chain[0][a].z <= z;
          chain[0][a].flip <= 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    etmb_cordic_cell #(.Step(g)) u_cell (
      .clk(clk), .en(en), .rin(chain[g]), .rout(chain[g+1])
    );
  end

  // Product stages.
  trig_t cx, sx, cy, sy, cz, sz;
  assign cx = chain[Steps][0].flip ? -chain[Steps][0].x : chain[Steps][0].x;
  assign sx = chain[Steps][0].flip ? -chain[Steps][0].y : chain[Steps][0].y;
  assign cy = chain[Steps][1].flip ? -chain[Steps][1].x : chain[Steps][1].x;
  assign sy = chain[Steps][1].flip ? -chain[Steps][1].y : chain[Steps][1].y;
  assign cz = chain[Steps][2].flip ? -chain[Steps][2].x : chain[Steps][2].x;
  assign sz = chain[Steps][2].flip ? -chain[Steps][2].y : chain[Steps][2].y;

  trig_t a_cx, a_sx, a_cy, a_sy, a_cz, a_sz;
  trig_t p_sxsy, p_czsy, p_sysz;
  always_ff @(posedge clk) begin
    if (en) begin
      a_cx <= cx; a_sx <= sx; a_cy <= cy; a_sy <= sy; a_cz <= cz; a_sz <= sz;
      p_sxsy <= mul24(sx, sy);
      p_czsy <= mul24(cz, sy);
      p_sysz <= mul24(sy, sz);
    end
  end

  trig_t t [9];
  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= mul24(a_cy, a_cz);
      t[1] <= mul24(a_cx, a_sz) + mul24(a_cz, p_sxsy);
      t[2] <= mul24(a_sx, a_sz) - mul24(a_cx, p_czsy);
      t[3] <= -mul24(a_cy, a_sz);
      t[4] <= mul24(a_cx, a_cz) - mul24(a_sx, p_sysz);
      t[5] <= mul24(a_cz, a_sx) + mul24(a_cx, p_sysz);
      t[6] <= a_sy;
      t[7] <= -mul24(a_cy, a_sx);
      t[8] <= mul24(a_cx, a_cy);
    end
  end

  trig_t u [9];
  always_ff @(posedge clk) begin
    if (en) begin
      u <= t;
    end
  end

  logic [31:0] m [9];
  side_t sd;
  assign sd = side[Depth-2];
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= scaled(u[0], sd.kx); m[1] <= scaled(u[1], sd.kx); m[2] <= scaled(u[2], sd.kx);
      m[3] <= scaled(u[3], sd.ky); m[4] <= scaled(u[4], sd.ky); m[5] <= scaled(u[5], sd.ky);
      m[6] <= scaled(u[6], sd.kz); m[7] <= scaled(u[7], sd.kz); m[8] <= scaled(u[8], sd.kz);
    end
  end

  assign r0c0 = m[0]; assign r0c1 = m[1]; assign r0c2 = m[2];
  assign r1c0 = m[3]; assign r1c1 = m[4]; assign r1c2 = m[5];
  assign r2c0 = m[6]; assign r2c1 = m[7]; assign r2c2 = m[8];
  assign trans_x = side[Depth-1].px;
  assign trans_y = side[Depth-1].py;
  assign trans_z = side[Depth-1].pz;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && stall_out |=> valid_out && $stable(r0c0) && $stable(trans_x))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    stall_in |-> valid_out && stall_out)
    else $error("stall without a held result");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !valid_out)
    else $error("result valid after reset");
endmodule

FILE: hw/rtl/etmb_cordic_cell.sv
// One CORDIC rotation cell for three angles, registered.
module etmb_cordic_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic en,
  input  etmb_pkg::rot_t rin [3],
  output etmb_pkg::rot_t rout [3]
);
  import etmb_pkg::*;

  rot_t rot_next [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rot_next[a].flip = rin[a].flip;
      if (!rin[a].z[TrigW-1]) begin
        rot_next[a].x = rin[a].x - (rin[a].y >>> Step);
        rot_next[a].y = rin[a].y + (rin[a].x >>> Step);
        rot_next[a].z = rin[a].z - atan_q24(5'(Step));
      end else begin
        rot_next[a].x = rin[a].x + (rin[a].y >>> Step);
        rot_next[a].y = rin[a].y - (rin[a].x >>> Step);
        rot_next[a].z = rin[a].z + atan_q24(5'(Step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rout <= rot_next;
    end
  end
endmodule

FILE: sim/euler_trs_matrix_builder_top_tb.sv
// Testbench for the Euler rotation, scale and translation matrix builder.
module euler_trs_matrix_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSteps = etmb_pkg::CordicStepsDefault;
  localparam int Latency = ((NumSteps < 24) ? NumSteps : 24) + 5;
  localparam int NumRandom = 900;
  localparam int WatchdogLimit = 20000;
  localparam int LongHold = 200;

  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

  typedef struct {
    logic signed [15:0] ax, ay, az, kx, ky, kz;
    logic signed [31:0] px, py, pz;
  } object_t;

  typedef struct {
    logic signed [31:0] m [12];
  } matrix_t;

  // One directed row; has_exp marks rows whose result is typed in.
  typedef struct {
    object_t obj;
    bit has_exp;
    logic signed [31:0] m [12];
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic stall_in;
  logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [15:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic valid_out;
  logic stall_out = 1'b0;
  logic signed [31:0] r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
  logic signed [31:0] trans_x, trans_y, trans_z;

  matrix_t expected_q[$];
  bit failed = 1'b0;
  bit hold_recv = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;
  int quiet_cycles = 0;

  euler_trs_matrix_builder_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round24(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 23), 24);
  endfunction

  function automatic logic signed [31:0] to_q16(longint t, longint k);
    longint r;
    r = floor_shr(t * k + 64'sd32768, 16);
    return r[31:0];
  endfunction

  task automatic cordic_trig(input logic signed [15:0] ang, output longint c,
                             output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = longint'(etmb_pkg::GainQ24);
    y = 0;
    z = longint'(ang) * 2048;
    flip = 1'b0;
    if (z > longint'(etmb_pkg::HalfPiQ24)) begin
      z -= longint'(etmb_pkg::PiQ24);
      flip = 1'b1;
    end else if (z < -longint'(etmb_pkg::HalfPiQ24)) begin
      z += longint'(etmb_pkg::PiQ24);
      flip = 1'b1;
    end
    for (int i = 0; i < NumSteps && i < etmb_pkg::AtanEntries; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(etmb_pkg::atan_q24(5'(i)));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(etmb_pkg::atan_q24(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic build_matrix(input object_t o, output matrix_t r);
    longint cx, sx, cy, sy, cz, sz, sysz;
    cordic_trig(o.ax, cx, sx);
    cordic_trig(o.ay, cy, sy);
    cordic_trig(o.az, cz, sz);
    sysz = round24(sy, sz);
    r.m[0] = to_q16(round24(cy, cz), longint'(o.kx));
    r.m[1] = to_q16(round24(cx, sz) + round24(cz, round24(sx, sy)), longint'(o.kx));
    r.m[2] = to_q16(round24(sx, sz) - round24(cx, round24(cz, sy)), longint'(o.kx));
    r.m[3] = to_q16(-round24(cy, sz), longint'(o.ky));
    r.m[4] = to_q16(round24(cx, cz) - round24(sx, sysz), longint'(o.ky));
    r.m[5] = to_q16(round24(cz, sx) + round24(cx, sysz), longint'(o.ky));
    r.m[6] = to_q16(sy, longint'(o.kz));
    r.m[7] = to_q16(-round24(cy, sx), longint'(o.kz));
    r.m[8] = to_q16(round24(cx, cy), longint'(o.kz));
    r.m[9] = o.px;
    r.m[10] = o.py;
    r.m[11] = o.pz;
  endtask

  function automatic object_t random_object();
    object_t o;
    o.ax = 16'($urandom);
    o.ay = 16'($urandom);
    o.az = 16'($urandom);
    o.kx = 16'($urandom);
    o.ky = 16'($urandom);
    o.kz = 16'($urandom);
    o.px = $urandom;
    o.py = $urandom;
    o.pz = $urandom;
    // X angles near the quadrant fold at plus and minus pi/2 are worth extra hits.
    if ($urandom_range(0, 3) == 0) o.ax = ($urandom_range(0, 1) ? 16'sd12868 : -16'sd12868)
                                          + $signed(16'($urandom_range(0, 8))) - 16'sd4;
    return o;
  endfunction

  function automatic bit sender_idles();
    return (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
           ($urandom_range(0, 99) < (idle_mode == IDLE_BOTH ? 30 : 56));
  endfunction

  task automatic send_object(input object_t o, input bit has_exp, input matrix_t typed);
    matrix_t predicted;
    while (sender_idles()) begin
      valid_in <= 1'b0;
      @(posedge clk);
    end
    build_matrix(o, predicted);
    if (has_exp) predicted = typed;
    valid_in <= 1'b1;
    angle_x <= o.ax; angle_y <= o.ay; angle_z <= o.az;
    scale_x <= o.kx; scale_y <= o.ky; scale_z <= o.kz;
    pos_x <= o.px; pos_y <= o.py; pos_z <= o.pz;
    @(posedge clk);
    while (stall_in) @(posedge clk);
    expected_q.push_back(predicted);
  endtask

  // Receiver stall generator.
  always @(posedge clk) begin
    if (hold_recv) begin
      stall_out <= 1'b1;
    end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      stall_out <= ($urandom_range(0, 99) < (idle_mode == IDLE_BOTH ? 30 : 56));
    end else begin
      stall_out <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    logic signed [31:0] got [12];
    matrix_t want;
    if (!rst && valid_out && !stall_out) begin
      got = '{r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
              trans_x, trans_y, trans_z};
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        for (int f = 0; f < 12; f++) begin
          if (got[f] !== want.m[f]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, f, want.m[f], got[f]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((valid_in && !stall_in) || (valid_out && !stall_out)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    wait (idle_mode == IDLE_RECV);
    @(posedge clk);
    hold_recv <= 1'b1;
    repeat (LongHold) @(posedge clk);
    hold_recv <= 1'b0;
  end

  initial begin
    vector_t vectors[$];
    vector_t v;
    matrix_t none;
    int drain;
    // Zero angles and unit scales give the identity times the scale.
    v.obj = '{16'sd0, 16'sd0, 16'sd0, 16'sh0100, 16'sh0100, 16'sh0100, 32'sd0, 32'sd0, 32'sd0};
    v.has_exp = 1'b0;
    vectors.push_back(v);
    // Zero scales force every rotation entry to zero; positions pass through.
    v.obj = '{16'sh7FFF, -16'sh8000, 16'sd1234, 16'sd0, 16'sd0, 16'sd0,
              32'sh7FFFFFFF, -32'sh80000000, 32'sd5};
    v.has_exp = 1'b1;
    v.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, -32'sh80000000, 5};
    vectors.push_back(v);
    v.has_exp = 1'b0;
    // Angle extremes, the fold at pi/2, and scale extremes.
    v.obj = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              -32'sd1, 32'sd0, 32'sd1};
    vectors.push_back(v);
    v.obj = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
              32'sd0, 32'sd0, 32'sd0};
    vectors.push_back(v);
    v.obj = '{16'sd12868, 16'sd12869, -16'sd12868, 16'sh0100, -16'sh0100, 16'sh0080,
              32'sd0, 32'sd0, 32'sd0};
    vectors.push_back(v);
    v.obj = '{-16'sd12869, 16'sd12867, 16'sd25736, 16'sh7FFF, -16'sh8000, 16'sd1,
              32'sd0, 32'sd0, 32'sd0};
    vectors.push_back(v);
    v.obj = '{16'sd6434, -16'sd6434, 16'sd1, -16'sd1, 16'sh0100, 16'sh0100,
              32'sh00010000, 32'shFFFF0000, 32'sd0};
    vectors.push_back(v);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[i]) send_object(vectors[i].obj, vectors[i].has_exp,
                                     '{m: vectors[i].m});
    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_t'(p);
      for (int n = 0; n < NumRandom / 4; n++) send_object(random_object(), 1'b0, none);
    end
    valid_in <= 1'b0;
    idle_mode = IDLE_NONE;
    drain = 0;
    while (expected_q.size() != 0 && drain < WatchdogLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (Latency + 5) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
